// File: rtl/lrt_pkg.sv
// lrt_pkg: shared constants and lane control/status types for the lru tracker
// no dependencies; used by lrt_lane and lru_replacement_tracker

package lrt_pkg;

    localparam int DEF_MAX_ENTRIES = 8;
    localparam int DEF_KEY_BITS    = 16;

    localparam int CAP_BITS = 4;
    localparam int OCC_BITS = 4;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd3;

    // broadcast from the top level to every lane
    typedef struct packed {
        logic update;
        logic hit;
        logic full;
    } lane_ctrl_t;

    // reported by each lane
    typedef struct packed {
        logic valid;
        logic match;
        logic lru;
    } lane_stat_t;

endpackage

// File: rtl/lrt_lane.sv
// lrt_lane: one entry of the tracker with its key, valid bit and recency rank
// depends on lrt_pkg for the lane control and status structs

module lrt_lane #(
    parameter int KEY_BITS  = lrt_pkg::DEF_KEY_BITS,
    parameter int RANK_BITS = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrt_pkg::lane_ctrl_t  ctrl,
    input  logic [KEY_BITS-1:0]  req_key,
    input  logic [RANK_BITS-1:0] hit_rank,
    input  logic [RANK_BITS-1:0] last_rank,
    input  logic                 free_sel,
    output lrt_pkg::lane_stat_t  stat,
    output logic [KEY_BITS-1:0]  key,
    output logic [RANK_BITS-1:0] rank
);

    logic [KEY_BITS-1:0]  key_reg;
    logic                 valid_reg;
    logic [RANK_BITS-1:0] rank_reg;
    logic                 match;
    logic                 lru;
    logic                 write_en;
    logic                 age_en;

    assign match = valid_reg && (key_reg == req_key);
    assign lru   = valid_reg && (rank_reg == last_rank);

    // a miss fills the free slot, or the least recent one when full
    assign write_en = ctrl.update && !ctrl.hit && (ctrl.full ? lru : free_sel);

    always_comb
    begin
        if (ctrl.hit)
            age_en = ctrl.update && valid_reg && !match && (rank_reg < hit_rank);
        else
            age_en = ctrl.update && valid_reg && !write_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (write_en)
        begin
            valid_reg <= 1'b1;
            rank_reg  <= '0;
        end
        else if (ctrl.update && ctrl.hit && match)
        begin
            rank_reg <= '0;
        end
        else if (age_en)
        begin
            rank_reg <= rank_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
            key_reg <= req_key;
    end

    assign stat.valid = valid_reg;
    assign stat.match = match;
    assign stat.lru   = lru;
    assign key        = key_reg;
    assign rank       = rank_reg;

endmodule

// File: rtl/lru_replacement_tracker.sv
// lru_replacement_tracker: fully associative lru key tracker, top level
// depends on lrt_pkg and lrt_lane
//
//  channel | signals                                   | dir | beat
//  --------+-------------------------------------------+-----+------------------------
//  cfg     | cfg_valid, cfg_ready, capacity            | in  | capacity write
//  in      | in_valid, in_ready, request_key           | in  | one referenced key
//  out     | out_valid, out_ready, hit, evicted_valid, | out | one result per key
//          | evicted_key, occupancy                    |     |
//
// one key per cycle sustained while out_ready is high: lookup, victim choice and rank
// update all sit between the input register and the result register, and the result
// is registered when the key advances out of the input register
// reset empties the store (valid bits and ranks), capacity returns to three
// a held result stalls the input register, and in_ready drops once it is full
// cfg_ready is always high

module lru_replacement_tracker #(
    parameter int MAX_ENTRIES = lrt_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = lrt_pkg::DEF_KEY_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lrt_pkg::CAP_BITS-1:0] capacity,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [KEY_BITS-1:0]          request_key,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic                         evicted_valid,
    output logic [KEY_BITS-1:0]          evicted_key,
    output logic [lrt_pkg::OCC_BITS-1:0] occupancy
);

    localparam int RANK_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FILL_BITS = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_BITS  = (FILL_BITS > lrt_pkg::CAP_BITS) ?
                               FILL_BITS : lrt_pkg::CAP_BITS;

    logic [lrt_pkg::CAP_BITS-1:0] cap_reg;
    logic [KEY_BITS-1:0]          key_reg;
    logic                         key_vld_reg;
    logic [FILL_BITS-1:0]         fill_reg;
    logic [FILL_BITS-1:0]         fill_next;
    logic                         out_vld_reg;
    logic                         hit_reg;
    logic                         ev_vld_reg;
    logic [KEY_BITS-1:0]          ev_key_reg;
    logic [lrt_pkg::OCC_BITS-1:0] occ_reg;

    logic                         advance;
    logic [CMP_BITS-1:0]          cap_ext;
    logic [CMP_BITS-1:0]          eff_cap;
    logic [CMP_BITS-1:0]          fill_ext;
    logic                         full;
    logic [FILL_BITS-1:0]         fill_m1;
    logic [MAX_ENTRIES-1:0]       valid_vec;
    logic [MAX_ENTRIES-1:0]       match_vec;
    logic [MAX_ENTRIES-1:0]       lru_vec;
    logic [MAX_ENTRIES-1:0]       free_oh;
    logic                         hit_any;
    logic [RANK_BITS-1:0]         hit_rank;
    logic [KEY_BITS-1:0]          lru_key;
    logic [FILL_BITS+lrt_pkg::OCC_BITS-1:0] occ_wide;

    lrt_pkg::lane_ctrl_t          ctrl;
    lrt_pkg::lane_stat_t          stat   [MAX_ENTRIES];
    logic [KEY_BITS-1:0]          lane_key [MAX_ENTRIES];
    logic [RANK_BITS-1:0]         lane_rank[MAX_ENTRIES];

    // handshakes
    assign cfg_ready = 1'b1;
    assign advance   = key_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !key_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= lrt_pkg::CAP_RESET;
        else if (cfg_valid && cfg_ready)
            cap_reg <= capacity;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_vld_reg <= 1'b0;
        else if (in_ready)
            key_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            key_reg <= request_key;
    end

    // capacity clamped to 1..MAX_ENTRIES
    always_comb
    begin
        cap_ext  = CMP_BITS'(cap_reg);
        fill_ext = CMP_BITS'(fill_reg);
        if (cap_ext == '0)
            eff_cap = CMP_BITS'(1);
        else if (cap_ext > CMP_BITS'(MAX_ENTRIES))
            eff_cap = CMP_BITS'(MAX_ENTRIES);
        else
            eff_cap = cap_ext;
    end

    assign full    = (fill_ext >= eff_cap);
    assign fill_m1 = fill_reg - 1'b1;

    // ranks of valid entries are 0..fill-1 once each, so the oldest has fill-1
    assign ctrl.update = advance;
    assign ctrl.hit    = hit_any;
    assign ctrl.full   = full;

    assign free_oh = ~valid_vec & (valid_vec + 1'b1);

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_lane
        lrt_lane #(
            .KEY_BITS  (KEY_BITS),
            .RANK_BITS (RANK_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .req_key   (key_reg),
            .hit_rank  (hit_rank),
            .last_rank (fill_m1[RANK_BITS-1:0]),
            .free_sel  (free_oh[g]),
            .stat      (stat[g]),
            .key       (lane_key[g]),
            .rank      (lane_rank[g])
        );

        assign valid_vec[g] = stat[g].valid;
        assign match_vec[g] = stat[g].match;
        assign lru_vec[g]   = stat[g].lru;
    end

    // keys are unique among valid entries, so at most one lane matches
    always_comb
    begin
        hit_rank = '0;
        lru_key  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_rank = hit_rank | (lane_rank[i] & {RANK_BITS{match_vec[i]}});
            lru_key  = lru_key  | (lane_key[i]  & {KEY_BITS{lru_vec[i]}});
        end
    end

    assign hit_any   = |match_vec;
    assign fill_next = (!hit_any && !full) ? fill_reg + 1'b1 : fill_reg;
    assign occ_wide  = {{lrt_pkg::OCC_BITS{1'b0}}, fill_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                fill_reg <= fill_next;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg    <= hit_any;
            ev_vld_reg <= !hit_any && full;
            ev_key_reg <= (!hit_any && full) ? lru_key : '0;
            occ_reg    <= occ_wide[lrt_pkg::OCC_BITS-1:0];
        end
    end

    assign out_valid     = out_vld_reg;
    assign hit           = hit_reg;
    assign evicted_valid = ev_vld_reg;
    assign evicted_key   = ev_key_reg;
    assign occupancy     = occ_reg;

    // checks
    a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == fill_reg)
        else $error("fill count differs from number of valid entries");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("key present in more than one entry");

    a_single_lru: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != '0) |-> $onehot(lru_vec))
        else $error("no unique least recent entry");

    a_hit_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && hit_any) |=> (fill_reg == $past(fill_reg)))
        else $error("fill count changed on a hit");

endmodule
